[rtl/bank_mapper_with_clock_registers_defines.svh]
// Assertion macros shared by the bank mapper files.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BANK_MAPPER_WITH_CLOCK_REGISTERS_DEFINES_SVH
`define BANK_MAPPER_WITH_CLOCK_REGISTERS_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define BMC_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// The condition holds in the cycle after the trigger.
`define BMC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[rtl/bmc_pkg.sv]
package bmc_pkg;

  // Bus command carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Direction of the nibble-serial clock protocol.
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_READ  = 2'd1,
    DIR_WRITE = 2'd2
  } dir_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_ROM_BANK = 2'd0;
  localparam logic [1:0] CFG_MAX_RAM_BANK = 2'd1;
  localparam logic [1:0] CFG_RAM_PRESENT  = 2'd2;

  // Address regions, decoded from address bits 15..13.
  localparam logic [2:0] RG_MODE   = 3'd0;
  localparam logic [2:0] RG_ROM    = 3'd1;
  localparam logic [2:0] RG_RAMB   = 3'd2;
  localparam logic [2:0] RG_UNUSED = 3'd3;
  localparam logic [2:0] RG_EXT    = 3'd5;

  // Mode byte values.
  localparam logic [7:0] RAM_EN_MASK = 8'h0A;
  localparam logic [7:0] MODE_CLOCK  = 8'h0B;
  localparam logic [7:0] MODE_ONE    = 8'h0D;
  localparam logic [7:0] MODE_REG_LO = 8'h0B;
  localparam logic [7:0] MODE_REG_HI = 8'h0E;

  // Clock commands in the high nibble of a clock-mode write.
  localparam logic [3:0] CC_READ_NIB  = 4'h1;
  localparam logic [3:0] CC_WRITE_NIB = 4'h3;
  localparam logic [3:0] CC_CONTROL   = 4'h4;
  localparam logic [3:0] CC_SET_READ  = 4'h6;

  // Sub-commands of the control command.
  localparam logic [3:0] CTL_CLR_SHIFT = 4'h0;
  localparam logic [3:0] CTL_WRITE     = 4'h3;
  localparam logic [3:0] CTL_READ      = 4'h7;

  // Time word limits.
  localparam logic [5:0]  SEC_MAX      = 6'd59;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [11:0] MIN_MAX      = 12'd1439;
  localparam logic [11:0] MIN_PER_DAY  = 12'd1440;
  localparam logic [11:0] DAY_MAX      = 12'd356;
  localparam logic [4:0]  SHIFT_STEP   = 5'd4;
  localparam logic [4:0]  SHIFT_LAST   = 5'd24;

  // Request from the bank logic to the clock unit.
  typedef struct packed {
    logic       tick;
    logic       cmd_en;
    logic [7:0] data;
  } clk_req_t;

endpackage

[rtl/bmc_clock.sv]
`include "bank_mapper_with_clock_registers_defines.svh"

module bmc_clock import bmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  clk_req_t   req,
  output logic [3:0] reply_nibble
);

  logic [27:0] time_word, time_word_next;
  logic [5:0]  seconds, seconds_next;
  dir_t        direction, direction_next;
  logic [4:0]  nibble_shift, nibble_shift_next;
  logic [3:0]  reply_nibble_next;

  logic [5:0]  sec_inc;
  logic [27:0] t1, t2, base, ins;
  logic [31:0] tw_ext;

  always_comb begin
    time_word_next    = time_word;
    seconds_next      = seconds;
    direction_next    = direction;
    nibble_shift_next = nibble_shift;
    reply_nibble_next = reply_nibble;

    // Tick path: seconds, then minutes, then days and year.
    sec_inc = seconds + 6'd1;
    t1 = time_word;
    if (sec_inc > SEC_MAX) begin
      t1 = time_word + 28'd1;
    end
    t2 = t1;
    if (t1[11:0] > MIN_MAX) begin
      t2 = {t1[27:12] + 16'd1, t1[11:0] - MIN_PER_DAY};
    end

    tw_ext = {4'b0000, time_word};
    base = (nibble_shift == 5'd0) ? 28'd0 : time_word;
    ins  = {24'd0, req.data[3:0]} << nibble_shift;

    if (req.tick) begin
      seconds_next = (sec_inc > SEC_MAX) ? (sec_inc - SEC_PER_MIN) : sec_inc;
      if (t2[23:12] > DAY_MAX) begin
        time_word_next = {t2[27:24] + 4'd1, 12'd0, t2[11:0]};
      end else begin
        time_word_next = t2;
      end
    end else if (req.cmd_en) begin
      case (req.data[7:4])
        CC_READ_NIB: begin
          if (direction == DIR_READ) begin
            reply_nibble_next = tw_ext[{nibble_shift[4:2], 2'b00} +: 4];
            nibble_shift_next = (nibble_shift + SHIFT_STEP > SHIFT_LAST) ? 5'd0
                                : nibble_shift + SHIFT_STEP;
          end
        end
        CC_WRITE_NIB: begin
          if (direction == DIR_WRITE) begin
            if (nibble_shift < SHIFT_LAST) begin
              time_word_next    = base | ins;
              nibble_shift_next = nibble_shift + SHIFT_STEP;
              if (nibble_shift + SHIFT_STEP == SHIFT_LAST) begin
                direction_next = DIR_READ;
              end
            end else begin
              time_word_next = base;
            end
          end
        end
        CC_CONTROL: begin
          case (req.data[3:0])
            CTL_CLR_SHIFT: nibble_shift_next = 5'd0;
            CTL_WRITE: begin
              direction_next    = DIR_WRITE;
              nibble_shift_next = 5'd0;
            end
            CTL_READ: begin
              direction_next    = DIR_READ;
              nibble_shift_next = 5'd0;
            end
            default: ;
          endcase
        end
        CC_SET_READ: direction_next = DIR_READ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_word    <= 28'd0;
      seconds      <= 6'd0;
      direction    <= DIR_NONE;
      nibble_shift <= 5'd0;
      reply_nibble <= 4'd1;
    end else begin
      time_word    <= time_word_next;
      seconds      <= seconds_next;
      direction    <= direction_next;
      nibble_shift <= nibble_shift_next;
      reply_nibble <= reply_nibble_next;
    end
  end

  `BMC_ASSERT_NOW(a_shift_range, 1'b1, (nibble_shift <= SHIFT_LAST) && (nibble_shift[1:0] == 2'b00), "nibble shift left the 0..24 nibble grid")
  `BMC_ASSERT_NOW(a_seconds_range, 1'b1, seconds <= SEC_MAX, "seconds counter above 59")
  `BMC_ASSERT_NEXT(a_minute_roll, req.tick && (seconds == SEC_MAX), seconds == 6'd0, "seconds did not roll over at a minute")

endmodule

[rtl/bank_mapper_with_clock_registers.sv]
// Cartridge bank controller with a battery-backed clock. Each input word is a bus
// write, a bus read or a one-second tick (tuser selects which); each one gives exactly
// one output word holding the byte the controller drives on reads it answers itself,
// the flags saying whether the read or the write goes to the banked memory, and the
// ROM and RAM banks in force after the access. Words pass through an input register
// and a result register with the whole state update between them, so one word is
// accepted every cycle unless the output stalls; the rate is bounded only by the
// combinational state update path (bank clamp compares and the time-word adders).
// A full result register does not stop the input register from taking one more
// word. Configuration writes set the bank limits and whether RAM is fitted and
// should only be issued while no word is in flight.
`include "bank_mapper_with_clock_registers_defines.svh"

module bank_mapper_with_clock_registers import bmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  s_tuser,   // cmd[1:0]

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data[7:0], rom_bank_now[15:8],
                                 // ram_bank_now[19:16], zero[23:20]
  output logic [1:0]  m_tuser,   // read_from_memory[0], write_to_memory[1]

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  // Configuration registers.
  logic [7:0] max_rom_bank;
  logic [3:0] max_ram_bank;
  logic       ram_present;

  // Input register.
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;

  // Bank state.
  logic [7:0] mode_byte, mode_byte_next;
  logic       ram_enabled, ram_enabled_next;
  logic [7:0] rom_sel, rom_sel_next;
  logic [3:0] ram_sel, ram_sel_next;

  // Result of the word in the input register.
  logic [7:0] rd;
  logic       from_mem, to_mem;
  logic [7:0] rom_pick;
  logic [3:0] ram_pick;
  logic [2:0] region;
  logic       reg_mode;

  logic       out_free, adv;
  clk_req_t   creq;
  logic [3:0] reply_nibble;

  // The result register can take a word when empty or when its word leaves now.
  assign out_free = !m_tvalid || m_tready;
  assign adv      = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rom_bank <= 8'd127;
      max_ram_bank <= 4'd3;
      ram_present  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ROM_BANK: max_rom_bank <= cfg_wdata;
        CFG_MAX_RAM_BANK: max_ram_bank <= cfg_wdata[3:0];
        CFG_RAM_PRESENT:  ram_present  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd  <= s_tuser;
      s1_addr <= s_tdata[15:0];
      s1_data <= s_tdata[23:16];
    end
  end

  assign region   = s1_addr[15:13];
  assign reg_mode = mode_byte inside {[MODE_REG_LO:MODE_REG_HI]};

  always_comb begin
    mode_byte_next   = mode_byte;
    ram_enabled_next = ram_enabled;
    rom_sel_next     = rom_sel;
    ram_sel_next     = ram_sel;
    rd       = 8'd0;
    from_mem = 1'b0;
    to_mem   = 1'b0;

    // A ROM bank of zero reads as bank one, then both banks clamp to the fitted size.
    rom_pick = (s1_data == 8'd0) ? 8'd1 : s1_data;
    if (rom_pick > max_rom_bank) begin
      rom_pick = max_rom_bank;
    end
    ram_pick = (s1_data[3:0] > max_ram_bank) ? max_ram_bank : s1_data[3:0];

    case (s1_cmd)
      CMD_WRITE: begin
        case (region)
          RG_MODE: begin
            ram_enabled_next = ((s1_data & RAM_EN_MASK) == RAM_EN_MASK);
            mode_byte_next   = s1_data;
          end
          RG_ROM:    rom_sel_next = rom_pick;
          RG_RAMB:   ram_sel_next = ram_pick;
          RG_UNUSED: to_mem = 1'b0;
          RG_EXT: begin
            // In register mode the byte still lands in memory; otherwise RAM must be
            // both enabled and fitted.
            to_mem = reg_mode ? 1'b1 : (ram_enabled && ram_present);
          end
          default: to_mem = 1'b1;
        endcase
      end
      CMD_READ: begin
        from_mem = 1'b1;
        if (region == RG_EXT) begin
          if (reg_mode && (mode_byte != MODE_REG_HI)) begin
            from_mem = 1'b0;
            rd = (mode_byte == MODE_ONE) ? 8'd1 : {4'b0000, reply_nibble};
          end else if (!ram_present) begin
            from_mem = 1'b0;
            rd = 8'hFF;
          end
        end
      end
      default: ;
    endcase

    creq.tick   = adv && (s1_cmd == CMD_TICK);
    creq.cmd_en = adv && (s1_cmd == CMD_WRITE) && (region == RG_EXT) &&
                  (mode_byte == MODE_CLOCK);
    creq.data   = s1_data;
  end

  bmc_clock u_clock (
    .clk          (clk),
    .rst          (rst),
    .req          (creq),
    .reply_nibble (reply_nibble)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_byte   <= 8'd0;
      ram_enabled <= 1'b0;
      rom_sel     <= 8'd1;
      ram_sel     <= 4'd0;
    end else if (adv) begin
      mode_byte   <= mode_byte_next;
      ram_enabled <= ram_enabled_next;
      rom_sel     <= rom_sel_next;
      ram_sel     <= ram_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'b0000, ram_sel_next, rom_sel_next, rd};
      m_tuser <= {to_mem, from_mem};
    end
  end

  `BMC_ASSERT_NOW(a_flags_exclusive, m_tvalid, !(m_tuser[0] && m_tuser[1]), "read and write memory flags both set")
  `BMC_ASSERT_NEXT(a_result_loaded, adv, m_tvalid, "advanced word did not reach the result register")
  `BMC_ASSERT_NEXT(a_ram_bank_clamp, adv && !cfg_we && (s1_cmd == CMD_WRITE) && (region == RG_RAMB), ram_sel <= max_ram_bank, "RAM bank write was not clamped")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

import bmc_pkg::*;

// What the block is expected to return for one bus access or tick.
typedef struct packed {
  logic [7:0] read_data;
  logic       from_memory;
  logic       to_memory;
  logic [7:0] rom_now;
  logic [3:0] ram_now;
} bus_result_t;

// One input word as the sender offers it.
typedef struct packed {
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  data;
} bus_access_t;

// Keeps a private copy of the controller state, predicts the result of each
// accepted access and checks the output words against those predictions in order.
class mapper_result_board;
  logic [7:0]  rom_limit;
  logic [3:0]  ram_limit;
  logic        ram_fitted;
  logic [7:0]  mode;
  logic        ram_on;
  logic [7:0]  rom_sel;
  logic [3:0]  ram_sel;
  dir_t        direction;
  logic [4:0]  shift;
  logic [27:0] clock_word;
  logic [5:0]  secs;
  logic [3:0]  reply;
  bus_result_t awaited_results[$];
  int          errors;
  int          checked;

  function new();
    rom_limit  = 8'd127;
    ram_limit  = 4'd3;
    ram_fitted = 1'b1;
    mode       = 8'd0;
    ram_on     = 1'b0;
    rom_sel    = 8'd1;
    ram_sel    = 4'd0;
    direction  = DIR_NONE;
    shift      = 5'd0;
    clock_word = 28'd0;
    secs       = 6'd0;
    reply      = 4'd1;
    errors     = 0;
    checked    = 0;
  endfunction

  function void set_register(logic [1:0] index, logic [7:0] value);
    case (index)
      CFG_MAX_ROM_BANK: rom_limit = value;
      CFG_MAX_RAM_BANK: ram_limit = value[3:0];
      CFG_RAM_PRESENT:  ram_fitted = value[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  // One-second tick. The minute and day carries are each applied at most once.
  function void advance_clock();
    secs = secs + 6'd1;
    if (secs > SEC_MAX) begin
      secs = secs - SEC_PER_MIN;
      clock_word = clock_word + 28'd1;
    end
    if (clock_word[11:0] > MIN_MAX) begin
      clock_word[11:0] = clock_word[11:0] - MIN_PER_DAY;
      clock_word = clock_word + 28'h000_1000;
    end
    if (clock_word[23:12] > DAY_MAX) begin
      clock_word[23:12] = 12'd0;
      clock_word = clock_word + 28'h100_0000;
    end
  endfunction

  function void run_clock_command(logic [7:0] data);
    logic [27:0] shifted;
    case (data[7:4])
      CC_READ_NIB: begin
        if (direction == DIR_READ) begin
          shifted = clock_word >> shift;
          reply = shifted[3:0];
          shift = shift + SHIFT_STEP;
          if (shift > SHIFT_LAST) shift = 5'd0;
        end
      end
      CC_WRITE_NIB: begin
        if (direction == DIR_WRITE) begin
          if (shift == 5'd0) clock_word = 28'd0;
          if (shift < SHIFT_LAST) begin
            clock_word = clock_word | (28'(data[3:0]) << shift);
            shift = shift + SHIFT_STEP;
            if (shift == SHIFT_LAST) direction = DIR_READ;
          end
        end
      end
      CC_CONTROL: begin
        case (data[3:0])
          CTL_CLR_SHIFT: shift = 5'd0;
          CTL_WRITE: begin
            direction = DIR_WRITE;
            shift = 5'd0;
          end
          CTL_READ: begin
            direction = DIR_READ;
            shift = 5'd0;
          end
          default: ;
        endcase
      end
      CC_SET_READ: direction = DIR_READ;
      default: ;
    endcase
  endfunction

  // Applies a bus write and tells whether the byte also reaches memory.
  function logic bus_write(logic [15:0] addr, logic [7:0] data);
    logic [7:0] rom_pick;
    logic [3:0] ram_pick;
    logic       lands;
    lands = 1'b1;
    case (addr[15:13])
      RG_MODE: begin
        ram_on = ((data & RAM_EN_MASK) == RAM_EN_MASK);
        mode = data;
        lands = 1'b0;
      end
      RG_ROM: begin
        rom_pick = (data == 8'd0) ? 8'd1 : data;
        if (rom_pick > rom_limit) rom_pick = rom_limit;
        rom_sel = rom_pick;
        lands = 1'b0;
      end
      RG_RAMB: begin
        ram_pick = data[3:0];
        if (ram_pick > ram_limit) ram_pick = ram_limit;
        ram_sel = ram_pick;
        lands = 1'b0;
      end
      RG_UNUSED: lands = 1'b0;
      RG_EXT: begin
        if (mode < MODE_REG_LO || mode > MODE_REG_HI) lands = ram_on & ram_fitted;
        else if (mode == MODE_CLOCK) run_clock_command(data);
      end
      default: ;
    endcase
    return lands;
  endfunction

  function void note_access(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
    bus_result_t want;
    want = '0;
    case (cmd)
      CMD_WRITE: want.to_memory = bus_write(addr, data);
      CMD_READ: begin
        want.from_memory = 1'b1;
        if (addr[15:13] == RG_EXT) begin
          if (mode >= MODE_REG_LO && mode < MODE_REG_HI) begin
            want.from_memory = 1'b0;
            want.read_data = (mode == MODE_ONE) ? 8'd1 : {4'd0, reply};
          end else if (!ram_fitted) begin
            want.from_memory = 1'b0;
            want.read_data = 8'hFF;
          end
        end
      end
      CMD_TICK: advance_clock();
      default: ;
    endcase
    want.rom_now = rom_sel;
    want.ram_now = ram_sel;
    awaited_results.push_back(want);
  endfunction

  function void compare_field(string field, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result %0d, %s expected %h, got %h", $time, checked, field,
                 want_v, got_v);
    end
  endfunction

  function void check_result(logic [23:0] tdata, logic [1:0] tuser);
    bus_result_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result word %h/%h arrived with nothing awaited", $time, tdata, tuser);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("read_data", want.read_data, tdata[7:0]);
    compare_field("rom_bank_now", want.rom_now, tdata[15:8]);
    compare_field("ram_bank_now", {4'd0, want.ram_now}, {4'd0, tdata[19:16]});
    compare_field("padding", 8'd0, {4'd0, tdata[23:20]});
    compare_field("read_from_memory", {7'd0, want.from_memory}, {7'd0, tuser[0]});
    compare_field("write_to_memory", {7'd0, want.to_memory}, {7'd0, tuser[1]});
    checked++;
  endfunction
endclass

module testbench;

  // The command code that the block must treat as a no-op, and a register
  // index with no register behind it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_NO_REG = 2'd3;

  // Cycles with no word moving on either side before the run is declared hung.
  // The longest deliberate stall is the receiver hold-off.
  localparam int QUIET_LIMIT = 2000;

  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // address[15:0], data[23:16]
  logic [1:0]  s_tuser;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // read_data[7:0], rom_bank_now[15:8], ram_bank_now[19:16]
  logic [1:0]  m_tuser;   // read_from_memory[0], write_to_memory[1]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  mapper_result_board board = new();

  // Words waiting to be offered, and counts used to tell when the block is idle.
  bus_access_t access_queue[$];
  int          items_queued;
  int          items_sent;

  bank_mapper_with_clock_registers DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bytes lean toward the two extremes, which hit the bank clamps and the zero rule.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] mode_address();
    return 16'($urandom_range(0, 16'h1FFF));
  endfunction

  function automatic logic [15:0] ext_address();
    return 16'hA000 | 16'($urandom_range(0, 16'h1FFF));
  endfunction

  function automatic void add_access(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
    bus_access_t item;
    item.cmd  = cmd;
    item.addr = addr;
    item.data = data;
    access_queue.push_back(item);
    items_queued++;
  endfunction

  // Queues one random sequence. About a third are clock protocol exchanges
  // with random content, since the time word can only be reached through them;
  // the rest are bank writes, tick bursts, mode changes and plain noise.
  task automatic queue_random_sequence();
    int          kind;
    int          count;
    logic [11:0] mins;
    logic [11:0] days;
    logic [23:0] value;
    logic [7:0]  mode_val;
    logic [7:0]  data;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // Set the time. Minutes and days are steered toward their carry points;
      // now and then the sequence is cut short or a tick slips in between.
      case ($urandom_range(0, 4))
        0: mins = MIN_MAX;
        1: mins = MIN_MAX - 12'd1;
        2: mins = MIN_PER_DAY;
        3: mins = 12'hFFF;
        default: mins = 12'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: days = DAY_MAX;
        1: days = DAY_MAX - 12'd1;
        2: days = DAY_MAX + 12'd1;
        3: days = 12'hFFF;
        default: days = 12'($urandom);
      endcase
      value = {days, mins};
      if ($urandom_range(0, 3) != 0) add_access(CMD_WRITE, mode_address(), MODE_CLOCK);
      add_access(CMD_WRITE, ext_address(), {CC_CONTROL, CTL_WRITE});
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 6;
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 15) == 0) add_access(CMD_TICK, 16'($urandom), 8'($urandom));
        add_access(CMD_WRITE, ext_address(), {CC_WRITE_NIB, value[4 * (i % 6) +: 4]});
      end
    end else if (kind < 35) begin
      // Read the time back nibble by nibble, sometimes past the wrap of the shift.
      if ($urandom_range(0, 3) != 0) add_access(CMD_WRITE, mode_address(), MODE_CLOCK);
      add_access(CMD_WRITE, ext_address(), {CC_CONTROL, CTL_READ});
      count = $urandom_range(1, 9);
      repeat (count) begin
        add_access(CMD_WRITE, ext_address(), {CC_READ_NIB, 4'($urandom)});
        add_access(CMD_READ, ext_address(), 8'($urandom));
      end
    end else if (kind < 47) begin
      // Long bursts carry seconds into minutes.
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 4);
      repeat (count) add_access(CMD_TICK, 16'($urandom), 8'($urandom));
    end else if (kind < 60) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1) == 1)
          add_access(CMD_WRITE, 16'h2000 | 16'($urandom_range(0, 16'h1FFF)), pick_byte());
        else
          add_access(CMD_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)), pick_byte());
        if ($urandom_range(0, 2) == 0) add_access(CMD_READ, 16'($urandom), 8'($urandom));
      end
    end else if (kind < 72) begin
      // Switch mode, then access the external window.
      case ($urandom_range(0, 5))
        0: mode_val = MODE_REG_LO + 8'd1;
        1: mode_val = MODE_ONE;
        2: mode_val = MODE_REG_HI;
        3: mode_val = RAM_EN_MASK;
        4: mode_val = MODE_CLOCK;
        default: mode_val = pick_byte();
      endcase
      add_access(CMD_WRITE, mode_address(), mode_val);
      repeat ($urandom_range(1, 4))
        add_access(($urandom_range(0, 1) == 1) ? CMD_READ : CMD_WRITE, ext_address(),
                   8'($urandom));
    end else if (kind < 82) begin
      // Other clock commands, including ignored control values.
      add_access(CMD_WRITE, mode_address(), MODE_CLOCK);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: data = {CC_SET_READ, 4'($urandom)};
          1: data = {CC_CONTROL, 4'($urandom)};
          2: data = {CC_CONTROL, CTL_CLR_SHIFT};
          default: data = 8'($urandom);
        endcase
        add_access(CMD_WRITE, ext_address(), data);
        if ($urandom_range(0, 1) == 1) add_access(CMD_READ, ext_address(), 8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 4))
        add_access(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic queue_random(int items);
    int target;
    target = items_queued + items;
    while (items_queued < target) queue_random_sequence();
  endtask

  // Configuration writes take effect at the edge where cfg_we is high.
  task automatic write_register(logic [1:0] index, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_register(index, value);
  endtask

  task automatic configure(logic [7:0] rom_max, logic [7:0] ram_max, logic [7:0] present);
    write_register(CFG_MAX_ROM_BANK, rom_max);
    write_register(CFG_MAX_RAM_BANK, ram_max);
    write_register(CFG_RAM_PRESENT, present);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word was taken and every result has come back.
  task automatic drain();
    while (items_sent != items_queued || board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: offers queued words, holding each until taken, with random gaps.
  initial begin : access_driver
    bus_access_t offered;
    int          gap;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    offered = '0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        board.note_access(offered.cmd, offered.addr, offered.data);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap--;
          s_tvalid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          offered = access_queue.pop_front();
          s_tdata  <= {offered.data, offered.addr};
          s_tuser  <= offered.cmd;
          s_tvalid <= 1'b1;
          gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result word and throttles tready. After the first
  // sixty results it holds tready low, so the block fills up and has to push
  // back on the sender.
  initial begin : result_sink
    int stall;
    int run;
    int hold;
    int taken;
    bit held;
    m_tready <= 1'b0;
    stall = 0;
    run = 0;
    hold = 0;
    taken = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        board.check_result(m_tdata, m_tuser);
        taken++;
      end
      if (!held && taken >= 60) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (run > 0) begin
          run--;
        end else begin
          stall = pick_gap();
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : main_sequence
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MAX_ROM_BANK;
    cfg_wdata <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First setting: the reset values, written explicitly.
    configure(8'd127, 8'd3, 8'd1);

    // Directed part. A read in the external window with RAM fitted goes to memory.
    add_access(CMD_READ, 16'hA000, 8'hFF);
    // A ROM bank write of zero selects bank one; all ones clamps to the limit.
    add_access(CMD_WRITE, 16'h2000, 8'h00);
    add_access(CMD_WRITE, 16'h3FFF, 8'hFF);
    // The RAM bank takes the low nibble and clamps.
    add_access(CMD_WRITE, 16'h4000, 8'hFF);
    add_access(CMD_WRITE, 16'h5FFF, 8'hF2);
    // The dead region swallows writes; the other regions written here pass them to memory.
    add_access(CMD_WRITE, 16'h7FFF, 8'h55);
    add_access(CMD_WRITE, 16'h8000, 8'hAA);
    add_access(CMD_WRITE, 16'hFFFF, 8'h00);
    // With RAM disabled a window write stays out of memory; enabled, it lands.
    add_access(CMD_WRITE, 16'hBFFF, 8'h12);
    add_access(CMD_WRITE, 16'h0000, RAM_EN_MASK);
    add_access(CMD_WRITE, 16'hBFFF, 8'h12);
    // Clock mode: the reply nibble starts at one.
    add_access(CMD_WRITE, 16'h1FFF, MODE_CLOCK);
    add_access(CMD_READ, 16'hA000, 8'h00);
    // Write all ones into minutes and days; the sixth nibble flips to read.
    add_access(CMD_WRITE, 16'hA000, {CC_CONTROL, CTL_WRITE});
    repeat (6) add_access(CMD_WRITE, 16'hB123, {CC_WRITE_NIB, 4'hF});
    // Minutes over the day length carry into days, and days overflow into the year.
    add_access(CMD_TICK, 16'hFFFF, 8'hFF);
    add_access(CMD_WRITE, 16'hA000, {CC_CONTROL, CTL_READ});
    repeat (2) begin
      add_access(CMD_WRITE, 16'hA001, {CC_READ_NIB, 4'h0});
      add_access(CMD_READ, 16'hBFFE, 8'h00);
    end
    // The fixed-answer mode, and the unused command.
    add_access(CMD_WRITE, 16'h0000, MODE_ONE);
    add_access(CMD_READ, 16'hBFFF, 8'h00);
    add_access(CMD_UNUSED, 16'hFFFF, 8'hFF);
    queue_random(130);
    drain();

    // Widest banks, no RAM. Upper bits of the write data must be ignored.
    configure(8'd255, 8'hAF, 8'h80);
    queue_random(90);
    drain();

    // A zero ROM limit forces every ROM bank write to zero.
    configure(8'd0, 8'd0, 8'd1);
    queue_random(60);
    drain();

    configure(8'd1, 8'hF0, 8'h00);
    queue_random(60);
    drain();

    // Random limits, preceded by a write to the index with no register.
    write_register(CFG_NO_REG, 8'($urandom));
    configure(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(70);
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
